[rtl/core/blwe_pkg.sv]
// package for the base64 line wrapping encoder
// holds the job descriptor passed from front to back, constants and the alphabet lookup
// no dependencies
package blwe_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned WordW        = 24;
  localparam int unsigned CntW         = 3;
  localparam int unsigned QueueDepthDf = 2;

  localparam logic [ByteW-1:0] GroupsPerLineRst = 8'd19;
  localparam logic [ByteW-1:0] PadChar          = 8'h3D;
  localparam logic [ByteW-1:0] NewlineChar      = 8'h0A;

  // symbol counts of the three group kinds, and the character total of a partial group
  localparam logic [CntW-1:0] SymFull     = 3'd4;
  localparam logic [CntW-1:0] SymOneByte  = 3'd2;
  localparam logic [CntW-1:0] SymTwoByte  = 3'd3;
  localparam logic [CntW-1:0] TotPartial  = 3'd5;

  // one unit of work for the back end: a 24-bit group and how to spell it out
  typedef struct packed {
    logic [WordW-1:0] word;     // group bits, first byte in the high bits
    logic [CntW-1:0]  nsym;     // alphabet symbols taken from word
    logic [CntW-1:0]  ntot;     // total characters, pads and newline included
    logic             nl;       // last character is a newline
    logic             last;     // job closes the message
  } job_t;

  // standard base64 alphabet
  function automatic logic [ByteW-1:0] b64_sym(input logic [5:0] v);
    logic [ByteW-1:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

[rtl/core/blwe_front.sv]
// front end: accepts bytes, gathers groups, keeps the line count, issues jobs
// depends on blwe_pkg
module blwe_front import blwe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [ByteW-1:0] cfg_wr_data,
  input  logic             accept,
  input  logic [ByteW-1:0] data_byte,
  input  logic             final_byte,
  output logic             job_valid,
  output job_t             job
);

  logic [ByteW-1:0]   groups_per_line_r;
  logic [2*ByteW-1:0] held_bits_r, held_bits_nxt;
  logic [1:0]         held_count_r, held_count_nxt;
  logic [ByteW-1:0]   groups_in_line_r, groups_in_line_nxt;

  logic [ByteW-1:0] g_inc;
  logic [ByteW-1:0] g_after;
  logic             wrap;

  // line counter after a full group
  assign g_inc   = groups_in_line_r + 8'd1;
  assign wrap    = (g_inc == groups_per_line_r);
  assign g_after = wrap ? '0 : g_inc;

  // classify the byte and build the job
  always_comb begin
    held_bits_nxt      = held_bits_r;
    held_count_nxt     = held_count_r;
    groups_in_line_nxt = groups_in_line_r;
    job_valid          = 1'b0;
    job                = '0;
    job.last           = final_byte;
    if (held_count_r == 2'd2) begin
      job_valid          = 1'b1;
      job.word           = {held_bits_r, data_byte};
      job.nsym           = SymFull;
      job.nl             = wrap || (final_byte && (g_after != '0));
      job.ntot           = SymFull + {2'b00, job.nl};
      held_bits_nxt      = '0;
      held_count_nxt     = '0;
      groups_in_line_nxt = final_byte ? '0 : g_after;
    end else if (final_byte) begin
      job_valid          = 1'b1;
      job.nl             = 1'b1;
      job.ntot           = TotPartial;
      if (held_count_r == 2'd0) begin
        job.word = {data_byte, 16'h0000};
        job.nsym = SymOneByte;
      end else begin
        job.word = {held_bits_r[ByteW-1:0], data_byte, 8'h00};
        job.nsym = SymTwoByte;
      end
      held_bits_nxt      = '0;
      held_count_nxt     = '0;
      groups_in_line_nxt = '0;
    end else begin
      held_bits_nxt  = {held_bits_r[ByteW-1:0], data_byte};
      held_count_nxt = held_count_r + 2'd1;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      groups_per_line_r <= GroupsPerLineRst;
    end else if (cfg_wr_en) begin
      groups_per_line_r <= cfg_wr_data;
    end
  end

  // group and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bits_r      <= '0;
      held_count_r     <= '0;
      groups_in_line_r <= '0;
    end else if (accept) begin
      held_bits_r      <= held_bits_nxt;
      held_count_r     <= held_count_nxt;
      groups_in_line_r <= groups_in_line_nxt;
    end
  end

endmodule

[rtl/core/blwe_queue.sv]
// short job queue between front and back end
// depends on blwe_pkg
module blwe_queue import blwe_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDf
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push, do_pop;

  assign full     = (count_r == CntFull);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/blwe_back.sv]
// back end: while each character is taken, spells a job out one character per cycle into the output register
// depends on blwe_pkg
module blwe_back import blwe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_ready,
  input  job_t             job,
  output logic             job_done,
  output logic             out_valid,
  output logic [ByteW-1:0] out_char,
  output logic             out_run_end,
  output logic             out_message_end,
  input  logic             out_take
);

  logic [CntW-1:0]  idx_r;
  logic             valid_r;
  logic [ByteW-1:0] char_r;
  logic             run_end_r;
  logic             msg_end_r;

  logic             load;
  logic             is_end;
  logic [ByteW-1:0] char_nxt;
  logic [5:0]       sym;

  assign load     = job_ready && (!valid_r || out_take);
  assign is_end   = (idx_r == job.ntot - 3'd1);
  assign job_done = load && is_end;

  // symbol select for the current position
  always_comb begin
    unique case (idx_r[1:0])
      2'd0:    sym = job.word[23:18];
      2'd1:    sym = job.word[17:12];
      2'd2:    sym = job.word[11:6];
      default: sym = job.word[5:0];
    endcase
    if (idx_r < job.nsym) begin
      char_nxt = b64_sym(sym);
    end else if (job.nl && is_end) begin
      char_nxt = NewlineChar;
    end else begin
      char_nxt = PadChar;
    end
  end

  // position within the job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (load) begin
      idx_r <= is_end ? '0 : idx_r + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r    <= char_nxt;
      run_end_r <= is_end;
      msg_end_r <= is_end && job.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_char        = char_r;
  assign out_run_end     = run_end_r;
  assign out_message_end = msg_end_r;

endmodule

[rtl/core/base64_line_wrapping_encoder.sv]
// base64 encoder with line wrapping, top level
// latency: a byte that completes a group writes its job into the queue at its transfer; the
// first character is then registered into the output register, from where it can be popped
// throughput: one character per cycle while pop takes each one from the single-character
// output register and jobs are waiting in the queue
// reset: synchronous active-low rst_n clears queue, counters, group state; 19 groups per line
module base64_line_wrapping_encoder import blwe_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDf
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [ByteW-1:0] cfg_wr_data,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_final_byte,
  output logic             empty,
  input  logic             pop,
  output logic [ByteW-1:0] out_char,
  output logic             out_run_end,
  output logic             out_message_end
);

  logic accept;
  logic job_valid;
  job_t new_job;
  job_t head_job;
  logic q_empty;
  logic job_done;
  logic out_valid;

  assign accept = push && !full;
  assign empty  = !out_valid;

  // byte intake and grouping
  blwe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .final_byte  (in_final_byte),
    .job_valid   (job_valid),
    .job         (new_job)
  );

  // job queue
  blwe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept && job_valid),
    .push_job (new_job),
    .full     (full),
    .pop      (job_done),
    .head_job (head_job),
    .empty    (q_empty)
  );

  // character output
  blwe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_ready       (!q_empty),
    .job             (head_job),
    .job_done        (job_done),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end),
    .out_take        (pop)
  );

endmodule
